// ===== rtl/double_ended_queue_assert.svh =====
// assertion macros for the double-ended queue checker
// no dependencies; takes label, clock, reset, antecedent, consequent and message as arguments
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DEQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/deq_pkg.sv =====
// shared types and codes for the double-ended queue
// no dependencies
package deq_pkg;

   localparam int DEPTH_DEFAULT = 64;

   // command codes
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_CLEAR      = 3'd4;
   localparam logic [2:0] CMD_DUMP       = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] value;
   } deq_req_type;

   typedef struct packed {
      logic signed [31:0] word;
      logic [1:0]         status;
      logic               last;
   } deq_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic       wr_front;    // push at front
      logic       wr_back;     // push at back
      logic       rd_front;    // read front entry, advance front
      logic       rd_back;     // read back entry, drop it
      logic       clear;
      logic       dump_start;  // read entry at offset zero
      logic       dump_next;   // read entry at next offset
      logic       emit;        // load result register
      logic       emit_mem;    // result word from read data
      logic [1:0] emit_status;
      logic       emit_last;
   } deq_ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic empty;
      logic full;
      logic dump_last;
      logic out_free;
   } deq_sts_type;

endpackage

// ===== rtl/double_ended_queue.sv =====
// double-ended queue of signed 32-bit words, top level
// depends on deq_pkg, deq_ctrl and deq_datapath
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  deq_req_type (command, value)
//   rsp      out  rsp_valid/rsp_ready  deq_rsp_type (word, status, last)
//
// push, clear, no-op and every empty or full case: result loaded at the next edge
// pop: the read of the storage is registered, then the result register is loaded from it
// dump: a start read, then the entries from front to back, each read as the one before is emitted
// reset clears front index, count, dump offset and the result valid flag; storage and result word are not cleared
// a stalled result holds the sequencer; the next command is taken once it moves
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  deq_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output deq_rsp_type rsp_data
);

   deq_ctl_type ctl;
   deq_sts_type sts;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .command   (req_data.command),
      .sts       (sts),
      .ctl       (ctl)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .push_value (req_data.value),
      .sts        (sts),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/deq_datapath.sv =====
// storage, indexes and result register of the double-ended queue
// depends on deq_pkg; driven by deq_ctrl commands
module deq_datapath
   import deq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  deq_ctl_type ctl,
   input  logic [31:0] push_value,
   output deq_sts_type sts,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output deq_rsp_type rsp_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [31:0]      mem [DEPTH];
   logic [31:0]      rd_data_ff;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] dump_idx_ff, dump_idx_in;
   logic             rsp_valid_ff;
   deq_rsp_type      rsp_ff;

   logic [CNT_W-1:0] offset;
   logic [SUM_W-1:0] slot_sum;
   logic [IDX_W-1:0] slot;
   logic [IDX_W-1:0] front_dec;
   logic [IDX_W-1:0] front_inc;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;

   // offset from front for the access of this cycle
   always_comb begin
      if (ctl.wr_back) begin
         offset = count_ff;
      end else if (ctl.rd_back) begin
         offset = count_ff - CNT_W'(1);
      end else if (ctl.dump_next) begin
         offset = dump_idx_ff + CNT_W'(1);
      end else begin
         offset = '0;
      end
   end

   // circular slot: front plus offset, wrapped once
   assign slot_sum = SUM_W'(front_ff) + SUM_W'(offset);
   assign slot = (slot_sum >= SUM_W'(DEPTH)) ? IDX_W'(slot_sum - SUM_W'(DEPTH))
                                             : IDX_W'(slot_sum);

   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
   assign front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + IDX_W'(1);
   assign wr_addr   = ctl.wr_front ? front_dec : slot;
   assign rd_en     = ctl.rd_front | ctl.rd_back | ctl.dump_start | ctl.dump_next;

   // storage: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctl.wr_front || ctl.wr_back) begin
         mem[wr_addr] <= push_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[slot];
      end
   end

   // front index, count and dump offset
   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      dump_idx_in = dump_idx_ff;
      if (ctl.clear) begin
         front_in = '0;
         count_in = '0;
      end
      if (ctl.wr_front) begin
         front_in = front_dec;
         count_in = count_ff + CNT_W'(1);
      end
      if (ctl.wr_back) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (ctl.rd_front) begin
         front_in = front_inc;
         count_in = count_ff - CNT_W'(1);
      end
      if (ctl.rd_back) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (ctl.dump_start) begin
         dump_idx_in = '0;
      end
      if (ctl.dump_next) begin
         dump_idx_in = dump_idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         count_ff    <= '0;
         dump_idx_ff <= '0;
      end else begin
         front_ff    <= front_in;
         count_ff    <= count_in;
         dump_idx_ff <= dump_idx_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_ff.word   <= ctl.emit_mem ? rd_data_ff : '0;
         rsp_ff.status <= ctl.emit_status;
         rsp_ff.last   <= ctl.emit_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;
   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == CNT_W'(DEPTH));
   assign sts.dump_last = ((SUM_W'(dump_idx_ff) + SUM_W'(1)) == SUM_W'(count_ff));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

// ===== rtl/deq_ctrl.sv =====
// command sequencer of the double-ended queue
// depends on deq_pkg; drives deq_datapath
module deq_ctrl
   import deq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  command,
   input  deq_sts_type sts,
   output deq_ctl_type ctl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_DUMP
   } state_type;

   state_type state_ff, state_in;

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = sts.out_free;
            if (req_valid && sts.out_free) begin
               ctl.emit_last = 1'b1;
               unique case (command) inside
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     ctl.emit = 1'b1;
                     if (sts.full) begin
                        ctl.emit_status = ST_FULL;
                     end else begin
                        ctl.emit_status = ST_OK;
                        ctl.wr_front    = (command == CMD_PUSH_FRONT);
                        ctl.wr_back     = (command == CMD_PUSH_BACK);
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (sts.empty) begin
                        ctl.emit        = 1'b1;
                        ctl.emit_status = ST_EMPTY;
                     end else begin
                        ctl.rd_front = (command == CMD_POP_FRONT);
                        ctl.rd_back  = (command == CMD_POP_BACK);
                        state_in     = S_POP;
                     end
                  end
                  CMD_CLEAR: begin
                     ctl.clear       = 1'b1;
                     ctl.emit        = 1'b1;
                     ctl.emit_status = ST_OK;
                  end
                  CMD_DUMP: begin
                     if (sts.empty) begin
                        ctl.emit        = 1'b1;
                        ctl.emit_status = ST_EMPTY;
                     end else begin
                        ctl.dump_start = 1'b1;
                        state_in       = S_DUMP;
                     end
                  end
                  default: begin
                     ctl.emit        = 1'b1;
                     ctl.emit_status = ST_OK;
                  end
               endcase
            end
         end
         S_POP: begin
            if (sts.out_free) begin
               ctl.emit        = 1'b1;
               ctl.emit_mem    = 1'b1;
               ctl.emit_status = ST_OK;
               ctl.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_DUMP: begin
            if (sts.out_free) begin
               ctl.emit        = 1'b1;
               ctl.emit_mem    = 1'b1;
               ctl.emit_status = ST_OK;
               ctl.emit_last   = sts.dump_last;
               if (sts.dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  ctl.dump_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/deq_checker.sv =====
// port-level checks of the double-ended queue, bound to the top level
// depends on deq_pkg and double_ended_queue_assert.svh
`include "double_ended_queue_assert.svh"

module deq_checker
   import deq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input deq_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input deq_rsp_type rsp_data
);

   logic req_xfer;
   logic quick_cmd;

   assign req_xfer  = req_valid && req_ready;
   assign quick_cmd = (req_data.command == CMD_PUSH_FRONT) ||
                      (req_data.command == CMD_PUSH_BACK) ||
                      (req_data.command == CMD_CLEAR);

   // a stalled result holds its payload
   `DEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // push and clear answer at the next edge with a final result
   `DEQ_ASSERT_NEXT(a_quick_rsp, clock, reset, req_xfer && quick_cmd, rsp_valid && rsp_data.last, "push or clear result late")

   // empty and full results are single, final and carry no word
   `DEQ_ASSERT_SAME(a_err_rsp, clock, reset, rsp_valid && (rsp_data.status != ST_OK), rsp_data.last && (rsp_data.word == 32'sd0) && ((rsp_data.status == ST_EMPTY) || (rsp_data.status == ST_FULL)), "bad error result")

   // only dump transfers may be non-final, and those are ok
   `DEQ_ASSERT_SAME(a_mid_dump, clock, reset, rsp_valid && !rsp_data.last, rsp_data.status == ST_OK, "non-final result with error status")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the double_ended_queue block
// depends on deq_pkg and the double_ended_queue top level; predicts results itself unless a directed row gives one
`timescale 1ns / 1ps

module testbench;
   import deq_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEFAULT;

   // codes the block treats as no operation
   localparam logic [2:0] CMD_SPARE_SIX   = 3'd6;
   localparam logic [2:0] CMD_SPARE_SEVEN = 3'd7;

   localparam deq_rsp_type RSP_DONE  = '{word: 32'sd0, status: ST_OK, last: 1'b1};
   localparam deq_rsp_type RSP_EMPTY = '{word: 32'sd0, status: ST_EMPTY, last: 1'b1};
   localparam deq_rsp_type RSP_NONE  = '0;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] value;
      logic               typed;   // expected result written in the row
      deq_rsp_type        rsp;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   deq_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   deq_rsp_type rsp_data;

   // expectation written in the directed table, travels with the request
   logic        row_typed;
   deq_rsp_type row_typed_rsp;

   bit steady_mode;
   int error_count;
   int rsp_hold;

   // mirror of the queue
   logic signed [31:0] mirror_store [QUEUE_DEPTH];
   logic [5:0]         mirror_front;
   logic [6:0]         mirror_count;
   deq_rsp_type        expected_rsp_q [$];

   stim_row_type directed_rows [21] = '{
      '{CMD_POP_FRONT,   32'sd0,           1'b1, RSP_EMPTY},
      '{CMD_POP_BACK,    32'sd0,           1'b1, RSP_EMPTY},
      '{CMD_DUMP,        32'sd0,           1'b1, RSP_EMPTY},
      '{CMD_PUSH_FRONT,  32'sh7fff_ffff,   1'b1, RSP_DONE},
      '{CMD_PUSH_BACK,   32'sh8000_0000,   1'b1, RSP_DONE},
      '{CMD_PUSH_FRONT,  -32'sd1,          1'b1, RSP_DONE},
      '{CMD_PUSH_BACK,   32'sd0,           1'b1, RSP_DONE},
      '{CMD_PUSH_FRONT,  32'sh5a5a_5a5a,   1'b1, RSP_DONE},
      '{CMD_DUMP,        32'sd0,           1'b0, RSP_NONE},
      '{CMD_POP_FRONT,   32'sd0,           1'b0, RSP_NONE},
      '{CMD_POP_BACK,    32'sd0,           1'b0, RSP_NONE},
      '{CMD_SPARE_SIX,   -32'sd1,          1'b1, RSP_DONE},
      '{CMD_SPARE_SEVEN, 32'sh7fff_ffff,   1'b1, RSP_DONE},
      '{CMD_DUMP,        32'sd0,           1'b0, RSP_NONE},
      '{CMD_CLEAR,       -32'sd1,          1'b1, RSP_DONE},
      '{CMD_DUMP,        32'sd0,           1'b1, RSP_EMPTY},
      '{CMD_POP_BACK,    32'sd0,           1'b1, RSP_EMPTY},
      '{CMD_PUSH_BACK,   32'sd1,           1'b1, RSP_DONE},
      '{CMD_PUSH_FRONT,  32'sh8000_0000,   1'b1, RSP_DONE},
      '{CMD_POP_BACK,    32'sd0,           1'b0, RSP_NONE},
      '{CMD_POP_FRONT,   32'sd0,           1'b0, RSP_NONE}
   };

   double_ended_queue u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // gap length: mostly none or short, a few long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // word with the extremes mixed in
   function automatic logic signed [31:0] random_word();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // command mix that lets the queue grow while exercising every code
   function automatic logic [2:0] mixed_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return CMD_PUSH_FRONT;
      if (r < 50) return CMD_PUSH_BACK;
      if (r < 67) return CMD_POP_FRONT;
      if (r < 84) return CMD_POP_BACK;
      if (r < 87) return CMD_CLEAR;
      if (r < 96) return CMD_DUMP;
      return (r < 98) ? CMD_SPARE_SIX : CMD_SPARE_SEVEN;
   endfunction

   // work out the results of one accepted command and update the mirror
   task automatic predict_deque_results(input deq_req_type req);
      logic [5:0] slot;
      int         i;
      case (req.command) inside
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (mirror_count >= 7'(QUEUE_DEPTH)) begin
               expected_rsp_q.push_back('{32'sd0, ST_FULL, 1'b1});
            end else begin
               if (req.command == CMD_PUSH_FRONT) begin
                  mirror_front = mirror_front - 6'd1;
                  slot = mirror_front;
               end else begin
                  slot = mirror_front + 6'(mirror_count);
               end
               mirror_store[slot] = req.value;
               mirror_count = mirror_count + 7'd1;
               expected_rsp_q.push_back(RSP_DONE);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (mirror_count == 7'd0) begin
               expected_rsp_q.push_back(RSP_EMPTY);
            end else begin
               if (req.command == CMD_POP_FRONT) begin
                  slot = mirror_front;
                  mirror_front = mirror_front + 6'd1;
               end else begin
                  slot = mirror_front + 6'(mirror_count - 7'd1);
               end
               mirror_count = mirror_count - 7'd1;
               expected_rsp_q.push_back('{mirror_store[slot], ST_OK, 1'b1});
            end
         end
         CMD_CLEAR: begin
            mirror_front = 6'd0;
            mirror_count = 7'd0;
            expected_rsp_q.push_back(RSP_DONE);
         end
         CMD_DUMP: begin
            if (mirror_count == 7'd0) begin
               expected_rsp_q.push_back(RSP_EMPTY);
            end else begin
               for (i = 0; i < int'(mirror_count); i++) begin
                  slot = mirror_front + 6'(i);
                  expected_rsp_q.push_back('{mirror_store[slot], ST_OK,
                                             1'(i + 1 == int'(mirror_count))});
               end
            end
         end
         default: begin
            expected_rsp_q.push_back(RSP_DONE);
         end
      endcase
   endtask

   // predict on each request transfer, check each result transfer
   always @(posedge clock) begin : monitor
      deq_rsp_type want;
      int          size_before;
      if (!reset) begin
         if (req_valid && req_ready) begin
            size_before = expected_rsp_q.size();
            predict_deque_results(req_data);
            if (row_typed) begin
               while (expected_rsp_q.size() > size_before) void'(expected_rsp_q.pop_back());
               expected_rsp_q.push_back(row_typed_rsp);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("result with none expected: word %0d status %0d last %0d",
                      rsp_data.word, rsp_data.status, rsp_data.last);
               error_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.word !== want.word) begin
                  $error("word: expected %0d, actual %0d", want.word, rsp_data.word);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_data.last);
                  error_count++;
               end
            end
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else if (steady_mode || $urandom_range(0, 99) < 70) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         rsp_hold = idle_length();
      end
   end

   // one request transfer, entered and left at a falling edge
   task automatic drive_command(input logic [2:0] cmd, input logic signed [31:0] value,
                                input logic typed, input deq_rsp_type rsp);
      int gap;
      gap = steady_mode ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data      <= '{command: cmd, value: value};
      row_typed     <= typed;
      row_typed_rsp <= rsp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // run limit
   initial begin
      #50_000_000;
      $display("simulation failed");
      $finish;
   end

   // stimulus and end of run
   initial begin : stimulus
      int   n;
      int   drain;
      logic [2:0] cmd;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      row_typed     = 1'b0;
      row_typed_rsp = '0;
      steady_mode   = 1'b0;
      error_count   = 0;
      rsp_hold      = 0;
      mirror_front  = 6'd0;
      mirror_count  = 7'd0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         drive_command(directed_rows[r].command, directed_rows[r].value,
                       directed_rows[r].typed, directed_rows[r].rsp);
      end

      // mixed traffic with no idling on either side
      steady_mode = 1'b1;
      for (n = 0; n < 30; n++) drive_command(mixed_command(), random_word(), 1'b0, RSP_NONE);
      steady_mode = 1'b0;

      // fill to the top from both ends, push on full, dump everything
      while (mirror_count < 7'(QUEUE_DEPTH)) begin
         cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
         drive_command(cmd, random_word(), 1'b0, RSP_NONE);
      end
      drive_command(CMD_PUSH_FRONT, random_word(), 1'b0, RSP_NONE);
      drive_command(CMD_PUSH_BACK, random_word(), 1'b0, RSP_NONE);
      drive_command(CMD_DUMP, random_word(), 1'b0, RSP_NONE);

      // drain part of it from random ends
      for (n = 0; n < 20; n++) begin
         cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
         drive_command(cmd, random_word(), 1'b0, RSP_NONE);
      end

      // mixed traffic with idling
      for (n = 0; n < 30; n++) drive_command(mixed_command(), random_word(), 1'b0, RSP_NONE);
      drive_command(CMD_DUMP, 32'sd0, 1'b0, RSP_NONE);
      req_valid <= 1'b0;

      // wait for the outstanding results, then a little longer for strays
      drain = 0;
      while (expected_rsp_q.size() != 0 && drain < 100_000) begin
         @(posedge clock);
         drain++;
      end
      repeat (80) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         $error("%0d expected results never arrived", expected_rsp_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_datapath.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
tb/testbench.sv
